/* src/htcg_pkg.sv */
package htcg_pkg;

  localparam int TABLE_SLOTS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [2:0] OP_BIND  = 3'd0;
  localparam logic [2:0] OP_INVAL = 3'd1;
  localparam logic [2:0] OP_EXIT  = 3'd2;
  localparam logic [2:0] OP_ENQ   = 3'd3;
  localparam logic [2:0] OP_POP   = 3'd4;

  localparam logic [2:0] DEC_ACCEPTED = 3'd0;
  localparam logic [2:0] DEC_UNKNOWN  = 3'd1;
  localparam logic [2:0] DEC_OWNER    = 3'd2;
  localparam logic [2:0] DEC_STALE    = 3'd3;
  localparam logic [2:0] DEC_TARGET   = 3'd4;
  localparam logic [2:0] DEC_FULL     = 3'd5;

  localparam logic [2:0] VERB_ATTACK   = 3'd2;
  localparam logic [2:0] VERB_APPROACH = 3'd5;
  localparam logic [2:0] VERB_ENGAGE   = 3'd6;
  localparam logic [2:0] VERB_PICKUP   = 3'd7;

  localparam int QW = 32 + 32 + 32 + 3 + 32;

  typedef struct packed {
    logic        found;
    logic [2:0]  decision;
    logic [31:0] handle;
    logic [31:0] epoch;
    logic [31:0] owner;
    logic [31:0] target;
    logic [2:0]  verb;
    logic [31:0] seq;
  } result_t;

  function automatic logic needs_target(input logic [2:0] v);
    return (v == VERB_ATTACK) || (v == VERB_APPROACH) ||
           (v == VERB_ENGAGE) || (v == VERB_PICKUP);
  endfunction

endpackage

/* src/handle_table_command_gate.sv */
// Handle table and command gate.
// Input channel in_valid/in_ready carries one command word: operation, key,
// owner, actor, target and verb. Result channel out_valid/out_ready returns
// exactly one word per command.
// The block works on one command at a time and scans the slot table one slot
// per cycle through a single compare unit. Steps from acceptance to out_valid:
// bind or invalidate scan the slots for the key, and a bind that misses the
// key then searches for a dead slot; enqueue scans for the actor, then for the
// target; pop reads the queue memory, whose read is registered; scene exit,
// key zero, actor zero, pop of an empty queue and unused operation codes go
// straight to the result.
// in_ready is high only while the sequencer is idle and no result word waits,
// so the next command is accepted only after the receiver has taken the
// result word. A stalled receiver holds the result word in out_* until
// out_ready.
// Reset (rst_n low, synchronous) clears the slot table, the counters, the
// queue pointers and the result valid. The command queue lives in RAM and
// needs no clearing, since pop reads only entries that enqueue wrote.
module handle_table_command_gate #(
  parameter int TABLE_SLOTS = htcg_pkg::TABLE_SLOTS_DEF,
  parameter int QUEUE_DEPTH = htcg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_local_key,
  input  logic [31:0] in_owner_tag,
  input  logic [31:0] in_actor_handle,
  input  logic [31:0] in_target_handle,
  input  logic [2:0]  in_verb,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [2:0]  out_decision,
  output logic [31:0] out_handle_out,
  output logic [31:0] out_epoch_out,
  output logic [31:0] out_owner_out,
  output logic [31:0] out_target_out,
  output logic [2:0]  out_verb_out,
  output logic [31:0] out_sequence_out
);

  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QD = (QUEUE_DEPTH > 1) ? QUEUE_DEPTH : 2;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SW-1:0] LAST = SW'(TABLE_SLOTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KEY   = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;
  localparam logic [3:0] S_ACT   = 4'd3;
  localparam logic [3:0] S_TGT   = 4'd4;
  localparam logic [3:0] S_POP1  = 4'd5;
  localparam logic [3:0] S_POP2  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [31:0] slot_id_r    [TABLE_SLOTS];
  logic [31:0] slot_epoch_r [TABLE_SLOTS];
  logic [63:0] slot_key_r   [TABLE_SLOTS];
  logic [31:0] slot_owner_r [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_live_r;

  logic [31:0] next_handle_r, scene_epoch_r, next_seq_r;
  logic [QA-1:0] head_r;
  logic [CW-1:0] count_r;

  logic [3:0] state_r;
  logic [SW-1:0] idx_r;
  logic [2:0] op_r, verb_r;
  logic [63:0] key_r;
  logic [31:0] owner_r, actor_r, target_r;

  htcg_pkg::result_t res_r;
  logic out_valid_r;

  // one shared slot compare unit
  logic [31:0] cur_id, cur_epoch, cur_owner;
  logic [63:0] cur_key;
  logic cur_live, key_hit, id_hit_act, id_hit_tgt, at_last;
  assign cur_id    = slot_id_r[idx_r];
  assign cur_epoch = slot_epoch_r[idx_r];
  assign cur_owner = slot_owner_r[idx_r];
  assign cur_key   = slot_key_r[idx_r];
  assign cur_live  = slot_live_r[idx_r];
  assign key_hit   = cur_live && (cur_key == key_r);
  assign id_hit_act = (cur_id == actor_r);
  assign id_hit_tgt = (cur_id == target_r);
  assign at_last   = (idx_r == LAST);

  logic tgt_ok, q_full;
  assign tgt_ok = !htcg_pkg::needs_target(verb_r) ||
                  (id_hit_tgt && cur_live && cur_epoch == scene_epoch_r);
  assign q_full = (count_r >= CW'(QUEUE_DEPTH));

  // queue RAM
  logic q_we;
  logic [QA-1:0] q_waddr;
  logic [htcg_pkg::QW-1:0] q_wdata, q_rdata;
  logic [QA:0] wsum;
  assign q_we = (state_r == S_TGT) && tgt_ok && !q_full;
  assign wsum = {1'b0, head_r} + (QA+1)'(count_r);
  always_comb begin
    if (QUEUE_DEPTH > 1 && wsum >= (QA+1)'(QUEUE_DEPTH)) begin
      q_waddr = QA'(wsum - (QA+1)'(QUEUE_DEPTH));
    end else if (QUEUE_DEPTH > 1) begin
      q_waddr = wsum[QA-1:0];
    end else begin
      q_waddr = '0;
    end
  end
  assign q_wdata = {actor_r, target_r, owner_r, verb_r, next_seq_r + 32'd1};

  htcg_ram #(.WIDTH(htcg_pkg::QW), .DEPTH(QD)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r), .rdata(q_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  logic take;
  assign take = in_valid && in_ready;

  htcg_pkg::result_t start_res, slot_res;
  always_comb begin
    start_res = '0;
    start_res.decision = (in_operation == htcg_pkg::OP_ENQ && in_actor_handle == 32'd0) ?
                         htcg_pkg::DEC_UNKNOWN : htcg_pkg::DEC_ACCEPTED;
    slot_res = '0;
    slot_res.found  = cur_live;
    slot_res.handle = cur_id;
    slot_res.epoch  = cur_epoch;
    slot_res.owner  = cur_owner;
  end

  logic [QA-1:0] head_inc;
  assign head_inc = (QUEUE_DEPTH == 1 || head_r == QA'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      res_r <= '0;
      slot_live_r <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_id_r[i] <= '0;
        slot_epoch_r[i] <= '0;
        slot_key_r[i] <= '0;
        slot_owner_r[i] <= '0;
      end
      next_handle_r <= '0;
      scene_epoch_r <= '0;
      next_seq_r <= '0;
      head_r <= '0;
      count_r <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            op_r <= in_operation;
            key_r <= in_local_key;
            owner_r <= in_owner_tag;
            actor_r <= in_actor_handle;
            target_r <= in_target_handle;
            verb_r <= in_verb;
            idx_r <= '0;
            res_r <= start_res;
            unique case (in_operation)
              htcg_pkg::OP_BIND, htcg_pkg::OP_INVAL: begin
                state_r <= (in_local_key == 64'd0) ? S_DONE : S_KEY;
              end
              htcg_pkg::OP_EXIT: begin
                slot_live_r <= '0;
                scene_epoch_r <= scene_epoch_r + 32'd1;
                head_r <= '0;
                count_r <= '0;
                state_r <= S_DONE;
              end
              htcg_pkg::OP_ENQ: begin
                state_r <= (in_actor_handle == 32'd0) ? S_DONE : S_ACT;
              end
              htcg_pkg::OP_POP: begin
                state_r <= (count_r == '0) ? S_DONE : S_POP1;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_KEY: begin
          if (key_hit) begin
            if (op_r == htcg_pkg::OP_INVAL) begin
              res_r <= slot_res;
              slot_live_r[idx_r] <= 1'b0;
            end else if (cur_owner == owner_r) begin
              res_r <= slot_res;
            end
            state_r <= S_DONE;
          end else if (at_last) begin
            idx_r <= '0;
            state_r <= (op_r == htcg_pkg::OP_BIND) ? S_FREE : S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_FREE: begin
          if (!cur_live) begin
            next_handle_r <= next_handle_r + 32'd1;
            slot_id_r[idx_r] <= next_handle_r + 32'd1;
            slot_epoch_r[idx_r] <= scene_epoch_r;
            slot_key_r[idx_r] <= key_r;
            slot_owner_r[idx_r] <= owner_r;
            slot_live_r[idx_r] <= 1'b1;
            res_r.found <= 1'b1;
            res_r.handle <= next_handle_r + 32'd1;
            res_r.epoch <= scene_epoch_r;
            res_r.owner <= owner_r;
            state_r <= S_DONE;
          end else if (at_last) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_ACT: begin
          if (id_hit_act) begin
            if (!cur_live) begin
              res_r.decision <= htcg_pkg::DEC_UNKNOWN;
              state_r <= S_DONE;
            end else if (cur_epoch != scene_epoch_r) begin
              res_r.decision <= htcg_pkg::DEC_STALE;
              state_r <= S_DONE;
            end else if (owner_r == 32'd0 || cur_owner != owner_r) begin
              res_r.decision <= htcg_pkg::DEC_OWNER;
              state_r <= S_DONE;
            end else if (htcg_pkg::needs_target(verb_r)) begin
              if (target_r == 32'd0 || target_r == actor_r) begin
                res_r.decision <= htcg_pkg::DEC_TARGET;
                state_r <= S_DONE;
              end else begin
                idx_r <= '0;
                state_r <= S_TGT;
              end
            end else begin
              idx_r <= '0;
              state_r <= S_TGT;
            end
          end else if (at_last) begin
            res_r.decision <= htcg_pkg::DEC_UNKNOWN;
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TGT: begin
          if (tgt_ok) begin
            if (q_full) begin
              res_r.decision <= htcg_pkg::DEC_FULL;
            end else begin
              next_seq_r <= next_seq_r + 32'd1;
              count_r <= count_r + 1'b1;
              res_r.decision <= htcg_pkg::DEC_ACCEPTED;
              res_r.seq <= next_seq_r + 32'd1;
            end
            state_r <= S_DONE;
          end else if (id_hit_tgt || at_last) begin
            res_r.decision <= htcg_pkg::DEC_TARGET;
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_POP1: begin
          state_r <= S_POP2;
        end
        S_POP2: begin
          res_r.found <= 1'b1;
          res_r.handle <= q_rdata[htcg_pkg::QW-1 -: 32];
          res_r.target <= q_rdata[htcg_pkg::QW-33 -: 32];
          res_r.owner <= q_rdata[htcg_pkg::QW-65 -: 32];
          res_r.verb <= q_rdata[34:32];
          res_r.seq <= q_rdata[31:0];
          head_r <= head_inc;
          count_r <= count_r - 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_found        = res_r.found;
  assign out_decision     = res_r.decision;
  assign out_handle_out   = res_r.handle;
  assign out_epoch_out    = res_r.epoch;
  assign out_owner_out    = res_r.owner;
  assign out_target_out   = res_r.target;
  assign out_verb_out     = res_r.verb;
  assign out_sequence_out = res_r.seq;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE && !out_valid_r))
    else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(res_r))
    else $error("result dropped");
  a_enq_only: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |-> op_r == htcg_pkg::OP_ENQ)
    else $error("queue write outside enqueue");

endmodule

/* src/htcg_ram.sv */
module htcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
